FILE: rtl/kvc_pkg.sv
// Shared types and constants for the FIFO key-value cache.
// Holds the request/response payload structs, the sequencer states and the match status.
// No dependencies.
package kvc_pkg;

    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;

    localparam int SLOT_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int SUM_BITS   = SLOT_BITS + 1;
    localparam int CAP_BITS   = 5;
    localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [APB_IDX_BITS-1:0] REG_CAPACITY = '0;
    localparam logic [CAP_BITS-1:0]     CAP_RESET    = CAP_BITS'(16);

    typedef enum logic {
        CMD_PUT = 1'b0,
        CMD_GET = 1'b1
    } kvc_cmd_t;

    typedef struct packed {
        logic                  cmd;
        logic [KEY_BITS-1:0]   lookup_key;
        logic [VALUE_BITS-1:0] write_value;
    } kvc_req_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } kvc_rsp_t;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
    } kvc_match_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_APPLY,
        ST_RESP
    } kvc_state_t;

endpackage

FILE: rtl/kvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the key and value stores. No dependencies.
module kvc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/kvc_match.sv
// Shared key comparator: checks one stored key per cycle against the request key.
// Records the first valid matching slot. Depends on kvc_pkg.
module kvc_match (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  clear,
    input  logic                                  en,
    input  logic [kvc_pkg::SLOT_BITS-1:0]         idx,
    input  logic [kvc_pkg::KEY_BITS-1:0]          key,
    input  logic [kvc_pkg::KEY_BITS-1:0]          stored_key,
    input  logic [kvc_pkg::DEPTH-1:0]             valid,
    output kvc_pkg::kvc_match_t                   match
);

    import kvc_pkg::*;

    logic                 en_reg;
    logic [SLOT_BITS-1:0] idx_reg;
    kvc_match_t           match_reg;
    kvc_match_t           match_next;
    logic                 equal;

    assign equal = en_reg && valid[idx_reg] && (stored_key == key);

    always_comb
    begin
        match_next = match_reg;
        if (clear)
        begin
            match_next.hit  = 1'b0;
            match_next.slot = '0;
        end
        else if (equal && !match_reg.hit)
        begin
            match_next.hit  = 1'b1;
            match_next.slot = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg    <= 1'b0;
            idx_reg   <= '0;
            match_reg <= '0;
        end
        else
        begin
            en_reg    <= en;
            idx_reg   <= idx;
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

FILE: rtl/fifo_key_value_cache.sv
// Top level of the FIFO key-value cache: sequencer, ring bookkeeping, APB register.
// Depends on kvc_pkg, kvc_ram and kvc_match.
//
// Fully associative store of up to DEPTH key/value pairs with first-in-first-out
// replacement, limited at run time by the capacity register (APB byte address 0).
// For each request one comparator walks the key memory one slot per cycle; then the
// LAST state finishes the last compare, the APPLY state updates the stores and the
// RESP state loads the response register, holding while an earlier response is
// still stalled. Requests are taken one at a time; the response register lets a new
// request in while the previous response still waits. A get does not change age;
// a put to a stored key rewrites its value in place. Write the capacity only while idle.
module fifo_key_value_cache (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  kvc_pkg::kvc_req_t                     req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output kvc_pkg::kvc_rsp_t                     rsp,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [kvc_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [kvc_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [kvc_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready
);

    import kvc_pkg::*;

    kvc_state_t            state_reg, state_next;
    kvc_req_t              req_reg, req_next;
    logic [SLOT_BITS-1:0]  scan_idx_reg, scan_idx_next;
    logic [DEPTH-1:0]      valid_reg, valid_next;
    logic [SLOT_BITS-1:0]  oldest_reg, oldest_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [CAP_BITS-1:0]   cap_reg, cap_next;
    kvc_rsp_t              rsp_reg, rsp_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    logic                  match_clear;
    logic                  match_en;
    kvc_match_t            match;
    logic [KEY_BITS-1:0]   key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;
    logic                  key_we;
    logic                  val_we;
    logic [SLOT_BITS-1:0]  ins_slot;
    logic [SLOT_BITS-1:0]  val_waddr;
    logic                  cfg_write;

    function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] s);
        logic [SLOT_BITS-1:0] r;
        if (s == SLOT_BITS'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    kvc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (ins_slot),
        .wdata (req_reg.lookup_key),
        .raddr (scan_idx_reg),
        .rdata (key_rdata)
    );

    kvc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (req_reg.write_value),
        .raddr (match.slot),
        .rdata (val_rdata)
    );

    kvc_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (match_clear),
        .en         (match_en),
        .idx        (scan_idx_reg),
        .key        (req_reg.lookup_key),
        .stored_key (key_rdata),
        .valid      (valid_reg),
        .match      (match)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_BITS-1:2] == REG_CAPACITY);
    assign prdata    = (paddr[APB_ADDR_BITS-1:2] == REG_CAPACITY)
                       ? APB_DATA_BITS'(cap_reg) : '0;
    assign cap_next  = cfg_write ? pwdata[CAP_BITS-1:0] : cap_reg;
    assign match_en  = (state_reg == ST_SCAN);
    assign val_waddr = match.hit ? match.slot : ins_slot;

    always_comb
    begin
        logic [SLOT_BITS-1:0]  o1;
        logic [COUNT_BITS-1:0] c1;
        logic [COUNT_BITS-1:0] c2;
        logic [SUM_BITS-1:0]   sum;

        state_next     = state_reg;
        req_next       = req_reg;
        scan_idx_next  = scan_idx_reg;
        valid_next     = valid_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        match_clear    = 1'b0;
        key_we         = 1'b0;
        val_we         = 1'b0;

        // make room first when full, then place the new key after the newest entry
        if (count_reg >= COUNT_BITS'(DEPTH))
        begin
            o1 = slot_inc(oldest_reg);
            c1 = count_reg - 1'b1;
        end
        else
        begin
            o1 = oldest_reg;
            c1 = count_reg;
        end
        sum = SUM_BITS'(o1) + SUM_BITS'(c1);
        if (sum >= SUM_BITS'(DEPTH))
        begin
            sum = sum - SUM_BITS'(DEPTH);
        end
        ins_slot = sum[SLOT_BITS-1:0];
        c2       = c1 + 1'b1;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    scan_idx_next = '0;
                    match_clear   = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == SLOT_BITS'(DEPTH - 1))
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (req_reg.cmd == CMD_PUT)
                begin
                    val_we = 1'b1;
                    if (!match.hit)
                    begin
                        key_we = 1'b1;
                        if (count_reg >= COUNT_BITS'(DEPTH))
                        begin
                            valid_next[oldest_reg] = 1'b0;
                        end
                        valid_next[ins_slot] = 1'b1;
                        oldest_next          = o1;
                        count_next           = c2;
                        // drop the oldest entry when over capacity
                        if (CMP_BITS'(c2) > CMP_BITS'(cap_reg))
                        begin
                            valid_next[o1] = 1'b0;
                            oldest_next    = slot_inc(o1);
                            count_next     = c1;
                        end
                    end
                end
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit        = match.hit;
                    rsp_next.read_value = (req_reg.cmd == CMD_GET && match.hit)
                                          ? val_rdata : '0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            valid_reg     <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            valid_reg     <= valid_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule
